[src/dct_pkg.sv]
// Shared constants, cosine table and interface types of the 8x8 forward DCT.
package dct_pkg;

	// Block geometry
	localparam int BLOCK_DIM = 8;
	localparam int DIM_W     = $clog2(BLOCK_DIM);
	localparam int NPIX      = BLOCK_DIM * BLOCK_DIM;
	localparam int IDX_W     = $clog2(NPIX);
	localparam int SEQ_W     = 3 * DIM_W;

	// Pixel double buffer
	localparam int NBANK      = 2;
	localparam int BANK_W     = $clog2(NBANK);
	localparam int BANK_CNT_W = $clog2(NBANK + 1);

	// Datapath widths
	localparam int PIX_W     = 8;
	localparam int COS_W     = 13;
	localparam int COS_FRAC  = 13;
	localparam int PART_FRAC = 10;
	localparam int PART_W    = 20;
	localparam int FRAC_BITS = 4;
	localparam int COEF_W    = 15;
	localparam int PROD_W    = PART_W + COS_W;
	localparam int ACC_W     = PROD_W + DIM_W + 1;

	// Rounding shifts of the two passes
	localparam int ROW_SH = COS_FRAC - PART_FRAC;
	localparam int COL_SH = COS_FRAC + PART_FRAC - FRAC_BITS;

	localparam logic signed [ACC_W-1:0] ROW_HALF = ACC_W'(2 ** (ROW_SH - 1));
	localparam logic signed [ACC_W-1:0] COL_HALF = ACC_W'(2 ** (COL_SH - 1));
	localparam logic signed [ACC_W-1:0] PART_HI  = ACC_W'(2 ** (PART_W - 1) - 1);
	localparam logic signed [ACC_W-1:0] PART_LO  = ACC_W'(-(2 ** (PART_W - 1)));
	localparam logic signed [ACC_W-1:0] COEF_HI  = ACC_W'(2 ** (COEF_W - 1) - 1);
	localparam logic signed [ACC_W-1:0] COEF_LO  = ACC_W'(-(2 ** (COEF_W - 1)));

	// Output queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Cosine table K[k][x], 13 fraction bits, indexed by {k, x}
	localparam logic signed [COS_W-1:0] COS_TAB [NPIX] = '{
		 2896,  2896,  2896,  2896,  2896,  2896,  2896,  2896,
		 4017,  3406,  2276,   799,  -799, -2276, -3406, -4017,
		 3784,  1567, -1567, -3784, -3784, -1567,  1567,  3784,
		 3406,  -799, -4017, -2276,  2276,  4017,   799, -3406,
		 2896, -2896, -2896,  2896,  2896, -2896, -2896,  2896,
		 2276, -4017,   799,  3406, -3406,  -799,  4017, -2276,
		 1567, -3784,  3784, -1567, -1567,  3784, -3784,  1567,
		  799, -2276,  3406, -4017,  4017, -3406,  2276,  -799
	};

	// Pixel store write from the front end
	typedef struct packed {
		logic                    en;
		logic [BANK_W+IDX_W-1:0] addr;
		logic signed [PIX_W-1:0] data;
	} pix_wr_t;

	// Coefficient word into the output queue
	typedef struct packed {
		logic                     en;
		logic signed [COEF_W-1:0] coef;
		logic                     last;
	} coef_wr_t;

endpackage

[src/dct_front.sv]
// Front end: takes pixel words, level-shifts them and fills the two pixel banks.
module dct_front import dct_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [PIX_W-1:0] pixel,
	output logic             full,
	input  logic             blk_release,
	output logic             blk_ready,
	output pix_wr_t          pix_wr
);

	logic [IDX_W-1:0]      load_q;
	logic [BANK_W-1:0]     wr_bank_q;
	logic [BANK_CNT_W-1:0] filled_q;
	logic                  take;
	logic                  blk_done;

	// Stall input while both banks hold blocks not yet read by the back end
	assign full      = (filled_q == BANK_CNT_W'(NBANK));
	assign blk_ready = (filled_q != '0);
	assign take      = push && !full;
	assign blk_done  = take && (&load_q);

	// Subtract 128 by flipping the top bit
	always_comb begin
		pix_wr.en   = take;
		pix_wr.addr = {wr_bank_q, load_q};
		pix_wr.data = {~pixel[PIX_W-1], pixel[PIX_W-2:0]};
	end

	// Advance load position, swap banks at the end of a block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q    <= '0;
			wr_bank_q <= '0;
			filled_q  <= '0;
		end else begin
			if (take) begin
				load_q <= load_q + IDX_W'(1);
			end
			if (blk_done) begin
				wr_bank_q <= wr_bank_q + BANK_W'(1);
			end
			filled_q <= filled_q + BANK_CNT_W'(blk_done) - BANK_CNT_W'(blk_release);
		end
	end

endmodule

[src/dct_back.sv]
// Back end: row and column passes on one shared multiply-accumulate.
module dct_back import dct_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  pix_wr_t             pix_wr,
	input  logic                blk_ready,
	output logic                blk_release,
	input  logic [OQ_CNT_W-1:0] oq_count,
	output coef_wr_t            coef_wr
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROW  = 3'b010,
		ST_COL  = 3'b100
	} seq_st_t;

	seq_st_t               st_q;
	logic [SEQ_W-1:0]      cnt_q;
	logic [DIM_W-1:0]      sa, sb, sk;
	logic [BANK_W-1:0]     rd_bank_q;
	logic [OQ_CNT_W-1:0]   pend_q;
	logic [OQ_CNT_W:0]     occ;
	logic                  credit_ok;
	logic                  issue;
	logic                  cnt_end;
	logic                  col_start;

	// Memories
	logic signed [PIX_W-1:0]  pix_mem  [NBANK*NPIX];
	logic signed [PART_W-1:0] part_mem [NPIX];

	// Stage 1: read data and table coefficient
	logic                     vld_s1, first_s1, last_s1, row_s1;
	logic [IDX_W-1:0]         dst_s1;
	logic signed [PIX_W-1:0]  pix_rd_s1;
	logic signed [PART_W-1:0] part_rd_s1;
	logic signed [COS_W-1:0]  coef_s1;

	// Stage 2: product
	logic                     vld_s2, first_s2, last_s2, row_s2;
	logic [IDX_W-1:0]         dst_s2;
	logic signed [PART_W-1:0] opnd;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s2;

	// Stage 3: accumulate
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_next;
	logic                     res_vld_s3, row_s3;
	logic [IDX_W-1:0]         dst_s3;
	logic signed [ACC_W-1:0]  sum_s3;

	// Stage 4: round and saturate
	logic signed [ACC_W-1:0]  row_val;
	logic signed [ACC_W-1:0]  col_val;
	logic signed [PART_W-1:0] part_wdata;
	logic                     part_we;

	assign {sa, sb, sk} = cnt_q;
	assign cnt_end      = &cnt_q;

	// Reserve an output slot before each column dot product starts
	assign occ         = {1'b0, oq_count} + {1'b0, pend_q};
	assign credit_ok   = (occ < (OQ_CNT_W + 1)'(OQ_DEPTH));
	assign col_start   = (st_q == ST_COL) && (sk == '0) && credit_ok;
	assign issue       = (st_q == ST_ROW) || (st_q == ST_COL && (sk != '0 || credit_ok));
	assign blk_release = (st_q == ST_ROW) && cnt_end;

	// Sequence: row pass over {i, v, j}, column pass over {u, v, i}
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_q     <= '0;
			rd_bank_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (blk_ready) begin
						st_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					cnt_q <= cnt_q + SEQ_W'(1);
					if (cnt_end) begin
						st_q      <= ST_COL;
						rd_bank_q <= rd_bank_q + BANK_W'(1);
					end
				end
				ST_COL: begin
					if (issue) begin
						cnt_q <= cnt_q + SEQ_W'(1);
						if (cnt_end) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Track output slots reserved but not yet filled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + OQ_CNT_W'(col_start) - OQ_CNT_W'(coef_wr.en);
		end
	end

	// Pixel store: written by the front end, read by the row pass
	always_ff @(posedge clk) begin
		if (pix_wr.en) begin
			pix_mem[pix_wr.addr] <= pix_wr.data;
		end
		pix_rd_s1 <= pix_mem[{rd_bank_q, sa, sk}];
	end

	// Partial store: written by the row pass, read down columns
	always_ff @(posedge clk) begin
		if (part_we) begin
			part_mem[dst_s3] <= part_wdata;
		end
		part_rd_s1 <= part_mem[{sk, sb}];
	end

	// Valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			res_vld_s3 <= 1'b0;
		end else begin
			vld_s1     <= issue;
			vld_s2     <= vld_s1;
			res_vld_s3 <= vld_s2 && last_s2;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		coef_s1  <= COS_TAB[{(st_q == ST_ROW) ? sb : sa, sk}];
		first_s1 <= (sk == '0);
		last_s1  <= (&sk);
		row_s1   <= (st_q == ST_ROW);
		dst_s1   <= {sa, sb};
	end

	// Stage 2: multiply
	assign opnd = row_s1 ? PART_W'(pix_rd_s1) : part_rd_s1;
	assign prod = opnd * coef_s1;

	always_ff @(posedge clk) begin
		prod_s2  <= prod;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
		dst_s2   <= dst_s1;
	end

	// Stage 3: accumulate, hold the finished sum
	assign acc_next = first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= acc_next;
		end
		if (vld_s2 && last_s2) begin
			sum_s3 <= acc_next;
			row_s3 <= row_s2;
			dst_s3 <= dst_s2;
		end
	end

	// Stage 4: round half up and clamp
	assign row_val = (sum_s3 + ROW_HALF) >>> ROW_SH;
	assign col_val = (sum_s3 + COL_HALF) >>> COL_SH;

	always_comb begin
		if (row_val > PART_HI) begin
			part_wdata = PART_HI[PART_W-1:0];
		end else if (row_val < PART_LO) begin
			part_wdata = PART_LO[PART_W-1:0];
		end else begin
			part_wdata = row_val[PART_W-1:0];
		end
	end

	assign part_we = res_vld_s3 && row_s3;

	always_comb begin
		coef_wr.en   = res_vld_s3 && !row_s3;
		coef_wr.last = (&dst_s3);
		if (col_val > COEF_HI) begin
			coef_wr.coef = COEF_HI[COEF_W-1:0];
		end else if (col_val < COEF_LO) begin
			coef_wr.coef = COEF_LO[COEF_W-1:0];
		end else begin
			coef_wr.coef = col_val[COEF_W-1:0];
		end
	end

endmodule

[src/dct_ofifo.sv]
// Output queue of coefficient words between the back end and the result port.
module dct_ofifo import dct_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  coef_wr_t                 coef_wr,
	input  logic                     pop,
	output logic                     empty,
	output logic [OQ_CNT_W-1:0]      count,
	output logic signed [COEF_W-1:0] coefficient,
	output logic                     last_coef
);

	logic signed [COEF_W-1:0] coef_q [OQ_DEPTH];
	logic                     last_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]      wp_q;
	logic [OQ_PTR_W-1:0]      rp_q;
	logic [OQ_CNT_W-1:0]      cnt_q;
	logic                     take;

	assign empty       = (cnt_q == '0);
	assign count       = cnt_q;
	assign take        = pop && !empty;
	assign coefficient = coef_q[rp_q];
	assign last_coef   = last_q[rp_q];

	// Store incoming words; room is reserved upstream
	always_ff @(posedge clk) begin
		if (coef_wr.en) begin
			coef_q[wp_q] <= coef_wr.coef;
			last_q[wp_q] <= coef_wr.last;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (coef_wr.en) begin
				wp_q <= wp_q + OQ_PTR_W'(1);
			end
			if (take) begin
				rp_q <= rp_q + OQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + OQ_CNT_W'(coef_wr.en) - OQ_CNT_W'(take);
		end
	end

endmodule

[src/dct2_8x8_forward.sv]
// Top level of the 8x8 forward DCT: front end, back end and output queue.
// Each block takes 512 row-pass and 512 column-pass products on the single shared
// multiply-accumulate, and the sequencer passes through an idle state between blocks;
// the column pass stalls while no output queue slot is free.
// Two pixel banks let the next block load during the transform of the current one.
// Reset: arst_n clears all counters and the output queue; the pixel and partial stores keep data.
module dct2_8x8_forward import dct_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [PIX_W-1:0]         pixel,
	output logic                     full,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [COEF_W-1:0] coefficient,
	output logic                     last_coef
);

	pix_wr_t             pix_wr;
	coef_wr_t            coef_wr;
	logic                blk_ready;
	logic                blk_release;
	logic [OQ_CNT_W-1:0] oq_count;

	dct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.pixel       (pixel),
		.full        (full),
		.blk_release (blk_release),
		.blk_ready   (blk_ready),
		.pix_wr      (pix_wr)
	);

	dct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_wr      (pix_wr),
		.blk_ready   (blk_ready),
		.blk_release (blk_release),
		.oq_count    (oq_count),
		.coef_wr     (coef_wr)
	);

	dct_ofifo u_ofifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.coef_wr     (coef_wr),
		.pop         (pop),
		.empty       (empty),
		.count       (oq_count),
		.coefficient (coefficient),
		.last_coef   (last_coef)
	);

endmodule

[src/dct_chk.sv]
// Port checker of the 8x8 forward DCT and its bind to the top level.
module dct_chk import dct_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     push,
	input logic                     full,
	input logic                     empty,
	input logic                     pop,
	input logic signed [COEF_W-1:0] coefficient,
	input logic                     last_coef
);

	// Input side fills up only on an accepted word
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted pixel word");

	// A waiting word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(coefficient) && $stable(last_coef)))
		else $error("waiting coefficient word changed or vanished");

	// Blocks are 64 words long, so two last words never follow each other
	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last_coef) |=> (empty || !last_coef))
		else $error("last word followed directly by another last word");

endmodule

bind dct2_8x8_forward dct_chk u_chk (.*);

[verif/tb_dct2_8x8_forward.sv]
// Testbench for the 8x8 forward DCT: block stimulus, coefficient predictor and scoreboard.
`timescale 1ns / 100ps

module tb_dct2_8x8_forward;
	import dct_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_OFF     = 3000;
	localparam int DRAIN_CYCLES = 600;
	localparam int RAND_BLOCKS  = 4;

	// Own fixed-point cosine table, 13 fraction bits, indexed by {k, x}
	localparam int COS_K [64] = '{
		 2896,  2896,  2896,  2896,  2896,  2896,  2896,  2896,
		 4017,  3406,  2276,   799,  -799, -2276, -3406, -4017,
		 3784,  1567, -1567, -3784, -3784, -1567,  1567,  3784,
		 3406,  -799, -4017, -2276,  2276,  4017,   799, -3406,
		 2896, -2896, -2896,  2896,  2896, -2896, -2896,  2896,
		 2276, -4017,   799,  3406, -3406,  -799,  4017, -2276,
		 1567, -3784,  3784, -1567, -1567,  3784, -3784,  1567,
		  799, -2276,  3406, -4017,  4017, -3406,  2276,  -799
	};

	localparam int ROW_SHIFT = 3;
	localparam int COL_SHIFT = 19;
	localparam longint PART_MAX = 524287;
	localparam longint PART_MIN = -524288;
	localparam longint COEF_MAX = 16383;
	localparam longint COEF_MIN = -16384;

	typedef enum int {BLK_ZERO, BLK_FULL, BLK_CHECKER, BLK_NOISE, BLK_BINARY, BLK_RAMP} blk_kind_e;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic                     last;
	} coef_word_t;

	// Predict coefficients per 8x8 block and check each popped word against them
	class dct_scoreboard;
		int         shifted_pix [64];
		int         load_idx;
		coef_word_t coef_q [$];
		int         errors;

		function new();
			load_idx = 0;
			errors = 0;
		endfunction

		function longint round_shift(longint x, int s);
			return (x + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint saturate(longint x, longint lo, longint hi);
			if (x < lo)
				return lo;
			if (x > hi)
				return hi;
			return x;
		endfunction

		// Row pass then column pass, queue the 64 coefficients in (u, v) order
		function void transform_block();
			longint     acc;
			longint     partial [64];
			coef_word_t w;
			for (int i = 0; i < 8; i++) begin
				for (int v = 0; v < 8; v++) begin
					acc = 0;
					for (int j = 0; j < 8; j++)
						acc += longint'(COS_K[v*8+j]) * shifted_pix[i*8+j];
					partial[i*8+v] = saturate(round_shift(acc, ROW_SHIFT), PART_MIN, PART_MAX);
				end
			end
			for (int u = 0; u < 8; u++) begin
				for (int v = 0; v < 8; v++) begin
					acc = 0;
					for (int i = 0; i < 8; i++)
						acc += longint'(COS_K[u*8+i]) * partial[i*8+v];
					acc = saturate(round_shift(acc, COL_SHIFT), COEF_MIN, COEF_MAX);
					w.coef = acc[COEF_W-1:0];
					w.last = (u == 7 && v == 7);
					coef_q.push_back(w);
				end
			end
		endfunction

		// Store one accepted pixel; the 64th triggers the transform
		function void note_pixel(logic [PIX_W-1:0] p);
			shifted_pix[load_idx] = int'(p) - 128;
			if (load_idx == 63) begin
				load_idx = 0;
				transform_block();
			end else begin
				load_idx++;
			end
		endfunction

		// Compare one popped word with the oldest expectation
		function void check_coef(logic signed [COEF_W-1:0] coef, logic last);
			coef_word_t w;
			if (coef_q.size() == 0) begin
				$error("coefficient word with no expectation: coefficient %0d last_coef %0b",
					coef, last);
				errors++;
				return;
			end
			w = coef_q.pop_front();
			if (coef !== w.coef) begin
				$error("coefficient: expected %0d, actual %0d", w.coef, coef);
				errors++;
			end
			if (last !== w.last) begin
				$error("last_coef: expected %0b, actual %0b", w.last, last);
				errors++;
			end
		endfunction

		function int outstanding();
			return coef_q.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic [PIX_W-1:0]         pixel;
	logic                     full;
	logic                     empty;
	logic                     pop;
	logic signed [COEF_W-1:0] coefficient;
	logic                     last_coef;

	dct_scoreboard sb;
	bit            quiet;
	int            cycles;

	dct2_8x8_forward DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.pixel       (pixel),
		.full        (full),
		.empty       (empty),
		.pop         (pop),
		.coefficient (coefficient),
		.last_coef   (last_coef)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one pixel, optionally after a short idle burst, and hold until taken
	task automatic send_pixel(input logic [PIX_W-1:0] p, input bit gaps);
		int n;
		if (gaps && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 4);
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
		push <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_pixel(p);
	endtask

	// Drive one full 8x8 block of the given pattern
	task automatic send_block(input blk_kind_e kind, input bit gaps);
		int               base;
		int               step;
		logic [PIX_W-1:0] p;
		base = $urandom_range(0, 255);
		step = $urandom_range(0, 64) - 32;
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				case (kind)
					BLK_ZERO:    p = '0;
					BLK_FULL:    p = '1;
					BLK_CHECKER: p = ((r + c) % 2 == 1) ? 8'hFF : 8'h00;
					BLK_BINARY:  p = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
					BLK_RAMP:    p = 8'(base + step * (r + c) + $urandom_range(0, 7));
					default:     p = 8'($urandom_range(0, 255));
				endcase
				send_pixel(p, gaps);
			end
		end
	endtask

	// Pop words with random stalls; hold off once for a long stretch to back the block up
	task automatic receive_words();
		int n;
		int taken;
		taken = 0;
		forever begin
			if (taken == 10) begin
				pop <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 4);
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			sb.check_coef(coefficient, last_coef);
			taken++;
		end
	endtask

	initial begin
		blk_kind_e kind;
		push = 1'b0;
		pixel = '0;
		pop = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		cycles = 0;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			receive_words();
		join_none

		// Directed: negative saturation edge, positive extreme, highest frequencies
		send_block(BLK_ZERO, 1'b1);
		send_block(BLK_FULL, 1'b0);
		send_block(BLK_CHECKER, 1'b1);

		// Random blocks; the last one runs with no idling on either side
		for (int b = 0; b < RAND_BLOCKS; b++) begin
			kind = blk_kind_e'($urandom_range(BLK_NOISE, BLK_RAMP));
			if (b == 0)
				kind = BLK_NOISE;
			if (b == RAND_BLOCKS - 1)
				quiet = 1'b1;
			send_block(kind, !quiet && ($urandom_range(0, 2) != 0));
		end
		push <= 1'b0;

		// Drain expectations, then watch for stray words
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[dct2_8x8_forward.f]
src/dct_pkg.sv
src/dct_front.sv
src/dct_back.sv
src/dct_ofifo.sv
src/dct2_8x8_forward.sv
src/dct_chk.sv
verif/tb_dct2_8x8_forward.sv
